>>> src/cseval_pkg.sv
// Shared types and constants for the curve segment sample evaluator.
// Depends on nothing; the front end, queue, back end and top import it.
`timescale 1ns / 1ps
`default_nettype none

package cseval_pkg;

	// Segment kind codes as they arrive on the kind port
	localparam logic [2:0] KIND_IDLE  = 3'd0;
	localparam logic [2:0] KIND_CONST = 3'd1;
	localparam logic [2:0] KIND_LINE  = 3'd2;
	localparam logic [2:0] KIND_QUAD  = 3'd3;
	localparam logic [2:0] KIND_CUBIC = 3'd4;

	localparam logic [15:0] IDLE_CODE = 16'h7fff;
	localparam logic [15:0] DAC_MAX   = 16'hffff;
	localparam int unsigned LINE_FRAC = 15;

	// Operation chosen by the front end
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CONST,
		OP_LINE,
		OP_QUAD,
		OP_CUBIC
	} op_t;

	// Fields that ride alongside the dividers
	typedef struct packed {
		op_t         op;
		logic        short_line;
		logic        neg;
		logic [15:0] idx;
		logic [15:0] p0;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic        chan;
	} cseval_sb_t;

	// Classified item handed from front end to back end
	typedef struct packed {
		op_t                op;
		logic [15:0]        idx;
		logic [15:0]        p0;
		logic [15:0]        p1;
		logic [15:0]        p2;
		logic [15:0]        p3;
		logic               chan;
		logic [31:0]        t;
		logic [31:0]        u;
		logic signed [31:0] step;
	} cseval_item_t;

endpackage

`default_nettype wire

>>> src/cseval_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses no package; instantiated by the front end.
`timescale 1ns / 1ps
`default_nettype none

module cseval_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 16,
	parameter int Q_W   = 32
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	logic [DEN_W-1:0] rem_i [NUM_W];
	logic [NUM_W-1:0] num_i [NUM_W];
	logic [NUM_W-1:0] quo_i [NUM_W];
	logic [DEN_W-1:0] den_i [NUM_W];

	assign rem_i[0] = '0;
	assign num_i[0] = num;
	assign quo_i[0] = '0;
	assign den_i[0] = den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		if (k > 0) begin : g_link
			assign rem_i[k] = rem_s[k-1];
			assign num_i[k] = num_s[k-1];
			assign quo_i[k] = quo_s[k-1];
			assign den_i[k] = den_s[k-1];
		end

		// Trial subtract of the divisor from the shifted partial remainder
		assign trial = {rem_i[k], num_i[k][NUM_W-1]};
		assign ge    = trial >= {1'b0, den_i[k]};
		assign diff  = trial - {1'b0, den_i[k]};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_s[k] <= num_i[k] << 1;
			quo_s[k] <= {quo_i[k][NUM_W-2:0], ge};
			den_s[k] <= den_i[k];
		end
	end

	assign quo = quo_s[NUM_W-1][Q_W-1:0];

endmodule

`default_nettype wire

>>> src/cseval_front.sv
// Front end: classifies items and runs the three divisions (t, u, line step).
// Depends on cseval_pkg and cseval_div.
`timescale 1ns / 1ps
`default_nettype none

module cseval_front import cseval_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [2:0]   kind,
	input  wire logic [15:0]  segment_length,
	input  wire logic [15:0]  sample_index,
	input  wire logic [15:0]  point_zero,
	input  wire logic [15:0]  point_one,
	input  wire logic [15:0]  point_two,
	input  wire logic [15:0]  point_three,
	input  wire logic         channel_tag,
	output logic              out_valid,
	output cseval_item_t      out_item
);

	localparam int NUM_W = 32 + FRAC_BITS;

	op_t         op;
	logic [15:0] mag;
	logic        neg;
	logic [31:0] rest;
	logic [NUM_W-1:0] num_t, num_u, num_l;
	logic [31:0] quo_t, quo_u, quo_l;
	cseval_sb_t  sb_in;

	logic       v_s  [NUM_W];
	cseval_sb_t sb_s [NUM_W];

	// Classify the kind; Bezier with zero length answers like idle
	always_comb begin
		case (kind)
			KIND_CONST: op = OP_CONST;
			KIND_LINE:  op = OP_LINE;
			KIND_QUAD:  op = (segment_length != 16'd0) ? OP_QUAD : OP_IDLE;
			KIND_CUBIC: op = (segment_length != 16'd0) ? OP_CUBIC : OP_IDLE;
			default:    op = OP_IDLE;
		endcase
	end

	// Numerators for the dividers
	assign neg   = point_one < point_zero;
	assign mag   = neg ? (point_zero - point_one) : (point_one - point_zero);
	assign rest  = {16'd0, segment_length} - {16'd0, sample_index};
	assign num_t = NUM_W'(sample_index) << FRAC_BITS;
	assign num_u = NUM_W'(rest) << FRAC_BITS;
	assign num_l = NUM_W'(mag) << LINE_FRAC;

	cseval_div #(.NUM_W(NUM_W), .DEN_W(16), .Q_W(32)) u_div_t (
		.clk(clk), .num(num_t), .den(segment_length), .quo(quo_t)
	);
	cseval_div #(.NUM_W(NUM_W), .DEN_W(16), .Q_W(32)) u_div_u (
		.clk(clk), .num(num_u), .den(segment_length), .quo(quo_u)
	);
	cseval_div #(.NUM_W(NUM_W), .DEN_W(16), .Q_W(32)) u_div_l (
		.clk(clk), .num(num_l), .den(segment_length - 16'd1), .quo(quo_l)
	);

	always_comb begin
		sb_in.op         = op;
		sb_in.short_line = segment_length <= 16'd1;
		sb_in.neg        = neg;
		sb_in.idx        = sample_index;
		sb_in.p0         = point_zero;
		sb_in.p1         = point_one;
		sb_in.p2         = point_two;
		sb_in.p3         = point_three;
		sb_in.chan       = channel_tag;
	end

	// Side fields and valid travel in step with the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 1; k < NUM_W; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sb_s[0] <= sb_in;
		for (int k = 1; k < NUM_W; k++) sb_s[k] <= sb_s[k-1];
	end

	// Assemble the classified item
	assign out_valid = v_s[NUM_W-1];
	always_comb begin
		out_item.op   = sb_s[NUM_W-1].op;
		out_item.idx  = sb_s[NUM_W-1].idx;
		out_item.p0   = sb_s[NUM_W-1].p0;
		out_item.p1   = sb_s[NUM_W-1].p1;
		out_item.p2   = sb_s[NUM_W-1].p2;
		out_item.p3   = sb_s[NUM_W-1].p3;
		out_item.chan = sb_s[NUM_W-1].chan;
		out_item.t    = quo_t;
		out_item.u    = quo_u;
		if (sb_s[NUM_W-1].short_line)
			out_item.step = '0;
		else if (sb_s[NUM_W-1].neg)
			out_item.step = -$signed(quo_l);
		else
			out_item.step = $signed(quo_l);
	end

endmodule

`default_nettype wire

>>> src/cseval_fifo.sv
// Two-entry queue between front end and back end.
// Depends on cseval_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module cseval_fifo import cseval_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire cseval_item_t  din,
	input  wire logic          rd,
	output logic               not_empty,
	output cseval_item_t       dout
);

	cseval_item_t mem_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   count_q;
	logic         do_wr, do_rd;

	assign not_empty = count_q != 2'd0;
	assign do_rd     = rd && not_empty;
	assign do_wr     = wr && ((count_q != 2'd2) || do_rd);
	assign dout      = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) wptr_q <= ~wptr_q;
			if (do_rd) rptr_q <= ~rptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= din;
	end

endmodule

`default_nettype wire

>>> src/cseval_back.sv
// Back end: Bezier weights, point products, DAC scaling and line saturation.
// Depends on cseval_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cseval_back import cseval_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire cseval_item_t  in_item,
	output logic               done,
	output logic [15:0]        sample_value,
	output logic               channel_out
);

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	function automatic logic [31:0] mulf(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[FRAC_BITS+31 -: 32];
	endfunction

	// Stage 1: squares and line product
	cseval_item_t       it_s1;
	logic               v_s1;
	logic [31:0]        tt_s1, uu_s1;
	logic signed [48:0] lprod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		it_s1    <= in_item;
		tt_s1    <= mulf(in_item.t, in_item.t);
		uu_s1    <= mulf(in_item.u, in_item.u);
		lprod_s1 <= $signed({1'b0, in_item.idx}) * in_item.step;
	end

	// Stage 2: weights and saturated line value
	logic [31:0]        q, r;
	logic [31:0]        w0, w1, w2, w3;
	logic signed [49:0] tot;
	logic [15:0]        line_v;

	always_comb begin
		q = ONE - (it_s1.t << 1) + tt_s1;
		r = ONE - (it_s1.u << 1) + uu_s1;
		if (it_s1.op == OP_CUBIC) begin
			w0 = mulf(q, ONE - it_s1.t);
			w1 = mulf(q, 32'd3 * it_s1.t);
			w2 = mulf(r, 32'd3 * it_s1.u);
			w3 = mulf(r, ONE - it_s1.u);
		end else begin
			w0 = q;
			w1 = (it_s1.t << 1) - (tt_s1 << 1);
			w2 = tt_s1;
			w3 = '0;
		end
		tot = $signed({17'd0, it_s1.p0, 17'd0}) >>> 2;
		tot = tot + 50'(lprod_s1);
		if (tot < 0)
			line_v = 16'd0;
		else if (tot[49:31] != '0)
			line_v = DAC_MAX;
		else
			line_v = tot[30:15];
	end

	cseval_item_t it_s2;
	logic         v_s2;
	logic [31:0]  w0_s2, w1_s2, w2_s2, w3_s2;
	logic [15:0]  line_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		it_s2   <= it_s1;
		w0_s2   <= w0;
		w1_s2   <= w1;
		w2_s2   <= w2;
		w3_s2   <= w3;
		line_s2 <= line_v;
	end

	// Stage 3: weight times point
	cseval_item_t it_s3;
	logic         v_s3;
	logic [31:0]  pr0_s3, pr1_s3, pr2_s3, pr3_s3;
	logic [15:0]  line_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		it_s3   <= it_s2;
		line_s3 <= line_s2;
		pr0_s3  <= mulf(w0_s2, {16'd0, it_s2.p0});
		pr1_s3  <= mulf(w1_s2, {16'd0, it_s2.p1});
		pr2_s3  <= mulf(w2_s2, {16'd0, it_s2.p2});
		pr3_s3  <= mulf(w3_s2, {16'd0, it_s2.p3});
	end

	// Stage 4: sum, scale to DAC code, pick the answer
	logic [31:0] y, ys;
	logic [15:0] val;

	always_comb begin
		y  = pr0_s3 + pr1_s3 + pr2_s3 + pr3_s3;
		ys = (y << 16) - y;
		case (it_s3.op)
			OP_CONST: val = it_s3.p0;
			OP_LINE:  val = line_s3;
			OP_QUAD:  val = ys[31:16];
			OP_CUBIC: val = ys[31:16];
			default:  val = IDLE_CODE;
		endcase
	end

	logic        done_q;
	logic [15:0] value_q;
	logic        chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		value_q <= val;
		chan_q  <= it_s3.chan;
	end

	assign done         = done_q;
	assign sample_value = value_q;
	assign channel_out  = chan_q;

endmodule

`default_nettype wire

>>> src/curve_segment_sample_evaluator.sv
// Top level of the curve segment sample evaluator.
// Depends on cseval_pkg, cseval_front, cseval_fifo and cseval_back.
//
// Usage:
//   Drive the segment fields and raise start; a transfer happens at each
//   rising edge with start high and busy low. busy never rises, so a new
//   sample may be issued every clock.
//   Each sample comes back once on sample_value / channel_out with done high
//   for one cycle, in issue order. The receiver cannot stall the block.
// Path: the pipelined dividers (one quotient bit per stage over 32 +
//   FRAC_BITS stages), one register in the queue and four back-end stages
//   (squares, weights, point products, sum and DAC scaling).
// Throughput: one sample per clock.
// Reset: arst_n clears all valid flags and the queue; samples in flight are
//   dropped and nothing is presented until new ones are issued.
`timescale 1ns / 1ps
`default_nettype none

module curve_segment_sample_evaluator import cseval_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [2:0]   kind,
	input  wire logic [15:0]  segment_length,
	input  wire logic [15:0]  sample_index,
	input  wire logic [15:0]  point_zero,
	input  wire logic [15:0]  point_one,
	input  wire logic [15:0]  point_two,
	input  wire logic [15:0]  point_three,
	input  wire logic         channel_tag,
	output logic              done,
	output logic [15:0]       sample_value,
	output logic              channel_out
);

	logic         f_valid;
	cseval_item_t f_item;
	logic         q_valid;
	cseval_item_t q_item;

	// Fully pipelined, always ready
	assign busy = 1'b0;

	cseval_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.kind           (kind),
		.segment_length (segment_length),
		.sample_index   (sample_index),
		.point_zero     (point_zero),
		.point_one      (point_one),
		.point_two      (point_two),
		.point_three    (point_three),
		.channel_tag    (channel_tag),
		.out_valid      (f_valid),
		.out_item       (f_item)
	);

	cseval_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (f_valid),
		.din       (f_item),
		.rd        (1'b1),
		.not_empty (q_valid),
		.dout      (q_item)
	);

	cseval_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.in_item      (q_item),
		.done         (done),
		.sample_value (sample_value),
		.channel_out  (channel_out)
	);

endmodule

`default_nettype wire

>>> bench/tb_curve_segment_sample_evaluator.sv
// Self-checking bench for curve_segment_sample_evaluator: directed and random samples
// of every segment kind, checked against a bit-accurate predictor in a small scoreboard.
// Depends on cseval_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_curve_segment_sample_evaluator;
	import cseval_pkg::*;

	localparam int FRAC_BITS  = 16;
	localparam int WDOG_LIMIT = 4000;
	localparam int DRAIN_WAIT = FRAC_BITS + 45;
	localparam int N_RANDOM   = 850;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] len;
		logic [15:0] idx;
		logic [15:0] p0;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic        chan;
	} seg_t;

	typedef struct packed {
		logic [15:0] value;
		logic        chan;
	} sample_t;

	// Fixed-point helpers at FRAC_BITS fraction bits, 32-bit wrap
	function automatic bit [31:0] fx_mul(bit [31:0] a, bit [31:0] b);
		bit [63:0] p;
		p = {32'b0, a} * {32'b0, b};
		return p[FRAC_BITS +: 32];
	endfunction

	function automatic bit [31:0] fx_div(bit [31:0] num, bit [31:0] den);
		bit [63:0] n;
		bit [63:0] q;
		n = {32'b0, num} << FRAC_BITS;
		q = n / {32'b0, den};
		return q[31:0];
	endfunction

	function automatic bit [15:0] dac_scale(bit [31:0] y);
		bit [31:0] s;
		s = y * 32'h0000ffff;
		return s[31:16];
	endfunction

	// Expected DAC code for one segment sample
	function automatic bit [15:0] sample_code(seg_t s);
		bit [31:0] one, t, u, q, r, w0, w1, w2, w3, y, len, idx;
		longint step, delta, total;
		one = 32'd1 << FRAC_BITS;
		len = {16'b0, s.len};
		idx = {16'b0, s.idx};
		case (s.kind)
			KIND_CONST: return s.p0;
			KIND_LINE: begin
				step = 0;
				if (len > 1) begin
					delta = (longint'(s.p1) - longint'(s.p0)) * (longint'(1) << LINE_FRAC);
					step = delta / longint'(len - 1);
				end
				total = longint'(s.p0) * (longint'(1) << LINE_FRAC) + longint'(idx) * step;
				if (total < 0) return 16'h0000;
				total = total >>> LINE_FRAC;
				if (total > 64'sd65535) return DAC_MAX;
				return total[15:0];
			end
			KIND_QUAD: begin
				if (len == 0) return IDLE_CODE;
				t  = fx_div(idx, len);
				w2 = fx_mul(t, t);
				w0 = one - (t + t) + w2;
				w1 = (t + t) - (w2 + w2);
				y  = fx_mul(w0, s.p0) + fx_mul(w1, s.p1) + fx_mul(w2, s.p2);
				return dac_scale(y);
			end
			KIND_CUBIC: begin
				if (len == 0) return IDLE_CODE;
				t  = fx_div(idx, len);
				q  = one - 2 * t + fx_mul(t, t);
				w0 = fx_mul(q, one - t);
				w1 = fx_mul(q, 3 * t);
				u  = fx_div(len - idx, len);
				r  = one - 2 * u + fx_mul(u, u);
				w2 = fx_mul(r, 3 * u);
				w3 = fx_mul(r, one - u);
				y  = fx_mul(w0, s.p0) + fx_mul(w1, s.p1) + fx_mul(w2, s.p2)
				   + fx_mul(w3, s.p3);
				return dac_scale(y);
			end
			default: return IDLE_CODE;
		endcase
	endfunction

	// Scoreboard: expected samples in issue order
	class sample_scoreboard;
		sample_t expected_q[$];
		int      errors;
		int      checked;

		function new();
			errors  = 0;
			checked = 0;
		endfunction

		function void note_issue(seg_t s);
			sample_t e;
			e.value = sample_code(s);
			e.chan  = s.chan;
			expected_q.push_back(e);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_sample(logic [15:0] value, logic chan);
			sample_t e;
			if (expected_q.size() == 0) begin
				report("unexpected sample", value, 16'h0);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (value !== e.value) report("sample_value", value, e.value);
			if (chan !== e.chan) report("channel_out", {15'b0, chan}, {15'b0, e.chan});
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [15:0] segment_length, sample_index;
	logic [15:0] point_zero, point_one, point_two, point_three;
	logic        channel_tag;
	logic        done;
	logic [15:0] sample_value;
	logic        channel_out;

	sample_scoreboard sb = new();
	int kind_count[8];
	int idle_cycles;

	curve_segment_sample_evaluator #(.FRAC_BITS(FRAC_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .segment_length(segment_length), .sample_index(sample_index),
		.point_zero(point_zero), .point_one(point_one), .point_two(point_two),
		.point_three(point_three), .channel_tag(channel_tag),
		.done(done), .sample_value(sample_value), .channel_out(channel_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		clk = 1'b0; arst_n = 1'b0; start = 1'b0;
		kind = '0; segment_length = 16'd1; sample_index = '0;
		point_zero = '0; point_one = '0; point_two = '0; point_three = '0;
		channel_tag = 1'b0;
	end

	// Monitor: note input transfers, check result strobes, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (start && !busy) begin
				sb.note_issue({kind, segment_length, sample_index, point_zero, point_one,
					point_two, point_three, channel_tag});
				kind_count[kind]++;
			end
			if (done)
				sb.check_sample(sample_value, channel_out);
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
				$display("curve_segment_sample_evaluator verification failed");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// Drive one sample; returns right after the edge that takes it, start still high
	task issue(seg_t s);
		kind <= s.kind; segment_length <= s.len; sample_index <= s.idx;
		point_zero <= s.p0; point_one <= s.p1; point_two <= s.p2; point_three <= s.p3;
		channel_tag <= s.chan;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_point();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic seg_t rand_segment();
		seg_t s;
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) s.kind = 3'($urandom_range(0, 7));
		else s.kind = 3'($urandom_range(1, 4));
		case ($urandom_range(0, 9))
			0: s.len = 16'($urandom);
			1: s.len = 16'hffff;
			2: s.len = 16'($urandom_range(0, 2));
			default: s.len = 16'($urandom_range(1, 300));
		endcase
		if ($urandom_range(0, 19) == 0 || s.len == 0) s.idx = 16'($urandom);
		else s.idx = 16'($urandom_range(0, s.len - 1));
		s.p0 = rand_point(); s.p1 = rand_point();
		s.p2 = rand_point(); s.p3 = rand_point();
		s.chan = 1'($urandom);
		return s;
	endfunction

	initial begin
		seg_t dir_q[$];
		int i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every kind, extremes, short and overrun lines, zero-length curves
		dir_q.push_back({KIND_IDLE, 16'd10, 16'd3, 16'h1234, 16'h0, 16'h0, 16'h0, 1'b0});
		dir_q.push_back({KIND_CONST, 16'd1, 16'd0, 16'hffff, 16'h0, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_CONST, 16'd1, 16'd0, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 1'b0});
		dir_q.push_back({KIND_LINE, 16'd100, 16'd0, 16'h0000, 16'hffff, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_LINE, 16'd100, 16'd99, 16'h0000, 16'hffff, 16'h0, 16'h0, 1'b0});
		dir_q.push_back({KIND_LINE, 16'd100, 16'd50, 16'hffff, 16'h0000, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_LINE, 16'd1, 16'd7, 16'h4321, 16'hffff, 16'h0, 16'h0, 1'b0});
		dir_q.push_back({KIND_LINE, 16'd0, 16'd7, 16'h8000, 16'h0000, 16'h0, 16'h0, 1'b0});
		dir_q.push_back({KIND_LINE, 16'd10, 16'hffff, 16'h8000, 16'hffff, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_LINE, 16'd10, 16'hffff, 16'h8000, 16'h0000, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_LINE, 16'hffff, 16'hfffe, 16'h0001, 16'hfffe, 16'h0, 16'h0, 1'b0});
		dir_q.push_back({KIND_QUAD, 16'd0, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'h0, 1'b0});
		dir_q.push_back({KIND_QUAD, 16'd64, 16'd0, 16'hffff, 16'h0, 16'h0, 16'h0, 1'b1});
		dir_q.push_back({KIND_QUAD, 16'd64, 16'd63, 16'h0, 16'hffff, 16'hffff, 16'h0, 1'b0});
		dir_q.push_back({KIND_QUAD, 16'hffff, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'h0, 1'b1});
		dir_q.push_back({KIND_QUAD, 16'd5, 16'd40, 16'h1000, 16'h2000, 16'h3000, 16'h0, 1'b0});
		dir_q.push_back({KIND_CUBIC, 16'd0, 16'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1});
		dir_q.push_back({KIND_CUBIC, 16'd1, 16'd0, 16'hffff, 16'h0, 16'h0, 16'hffff, 1'b0});
		dir_q.push_back({KIND_CUBIC, 16'd128, 16'd64, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1});
		dir_q.push_back({KIND_CUBIC, 16'hffff, 16'hfffe, 16'h0, 16'hffff, 16'h0, 16'hffff, 1'b0});
		dir_q.push_back({KIND_CUBIC, 16'd8, 16'd200, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1});
		dir_q.push_back({3'd5, 16'd8, 16'd2, 16'h1, 16'h2, 16'h3, 16'h4, 1'b0});
		dir_q.push_back({3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1});
		foreach (dir_q[k]) issue(dir_q[k]);

		// Random samples; no gaps in the middle stretch, one full drain midway
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 400) begin
				start <= 1'b0;
				do @(posedge clk); while (sb.expected_q.size() != 0);
			end
			if ((i < 300 || i > 550) && $urandom_range(0, 99) < 9)
				gap($urandom_range(1, 6));
			issue(rand_segment());
		end
		start <= 1'b0;

		// Drain
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d samples: idle/unused %0d, const %0d, line %0d, quad %0d, cubic %0d",
			sb.checked, kind_count[0] + kind_count[5] + kind_count[6] + kind_count[7],
			kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("curve_segment_sample_evaluator verification clean");
		end else begin
			$display("%0d mismatches, %0d samples never returned", sb.errors,
				sb.expected_q.size());
			$display("curve_segment_sample_evaluator verification failed");
		end
		$finish;
	end

endmodule
